// File: hw/rtl/dltq_pkg.sv
// Package for the delta-list timer queue.
// Holds the sequencer state type, operation and event codes, and the result record.
// No dependencies.
package dltq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int DUE_AW      = 4;
    localparam int CNT_W       = 5;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_ADV    = 2'd2;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WS,
        S_INS_LINK,
        S_REM_RD,
        S_REM_CMP,
        S_REM_ADD,
        S_REM_LINK,
        S_ADV_RD,
        S_ADV_CMP,
        S_ADV_P2,
        S_ADV_PR,
        S_FIN,
        S_FIN_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  expired_slot;
        logic [23:0] head_delay_ms;
        logic        last;
    } t_result;

endpackage

// File: hw/rtl/dltq_ifs.sv
// Valid/ready channel interfaces of the delta-list timer queue.
// One interface for the input word and one for the result word; no dependencies.
interface dltq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  slot_id;
    logic [23:0] period_ms;
    logic        periodic;
    logic [15:0] elapsed_ms;

    modport source (output valid, operation, slot_id, period_ms, periodic, elapsed_ms,
                    input ready);
    modport sink (input valid, operation, slot_id, period_ms, periodic, elapsed_ms,
                  output ready);
endinterface

interface dltq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [3:0]  expired_slot;
    logic [23:0] head_delay_ms;
    logic        last;

    modport source (output valid, event_kind, expired_slot, head_delay_ms, last,
                    input ready);
    modport sink (input valid, event_kind, expired_slot, head_delay_ms, last,
                  output ready);
endinterface

// File: hw/rtl/dltq_out_stage.sv
// Output register of the delta-list timer queue.
// Holds one result word until the sink takes it; uses dltq_pkg and dltq_out_if.
module dltq_out_stage
    import dltq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    output logic        o_free,
    dltq_out_if.source  o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.event_kind    = r_res.event_kind;
    assign o_out.expired_slot  = r_res.expired_slot;
    assign o_out.head_delay_ms = r_res.head_delay_ms;
    assign o_out.last          = r_res.last;

endmodule

// File: hw/rtl/delta_list_timer_queue.sv
// Delta-list timer queue: a sequencer walks one linked list through a link memory.
// Each visited entry takes a memory read, then a compare (and subtract) step.
// Add and remove walk the list from its head and end in one result word; advance drops
// each expired entry, reinserts periodic ones, then emits a word per expiry (one if none).
// The input is taken only between operations. Synchronous active-low reset empties the list.
// Depends on dltq_pkg, dltq_ifs and dltq_out_stage.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int DELAY_BITS = 24
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_in_if.sink    i_in,
    dltq_out_if.source o_out
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (DELAY_BITS > 16) ? DELAY_BITS : 16;

    typedef logic [AW-1:0]         t_addr;
    typedef logic [IW-1:0]         t_idx;
    typedef logic [DELAY_BITS-1:0] t_delay;
    typedef logic [CW-1:0]         t_cmp;

    localparam t_idx   NO_SLOT   = t_idx'(SLOT_COUNT);
    localparam t_delay DELAY_MAX = '1;

    t_delay m_delta [SLOT_COUNT];
    t_idx   m_succ  [SLOT_COUNT];
    t_delay m_per   [SLOT_COUNT];
    logic   m_rep   [SLOT_COUNT];

    t_state r_state, n_state;
    logic   r_adv, n_adv;
    logic [1:0] r_kind, n_kind;
    t_addr  r_s, n_s;
    t_delay r_d, n_d;
    t_idx   r_prev, n_prev;
    t_idx   r_cur, n_cur;
    t_delay r_pd, n_pd;
    t_idx   r_nx, n_nx;
    t_delay r_sd, n_sd;
    logic   r_eq, n_eq;
    logic [15:0] r_e, n_e;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_idx   r_head, n_head;
    t_delay r_hd, n_hd;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    t_addr  r_due [MAX_RESULTS];
    t_addr  n_due [MAX_RESULTS];
    t_delay r_rd_delta;
    t_idx   r_rd_succ;
    t_delay r_prd_per;
    logic   r_prd_rep;

    logic   lm_we;
    t_addr  lm_waddr;
    t_delay lm_wdelta;
    t_idx   lm_wsucc;
    t_addr  lm_raddr;
    logic   pm_we;
    t_addr  pm_addr;

    logic    accept;
    logic    id_ok;
    t_addr   ida;
    t_delay  per_sat;
    t_idx    s_ext;
    t_addr   due_sel;
    logic    ins_done;
    logic    out_free;
    logic    out_load;
    logic    res_last;
    t_result res;
    logic [DELAY_BITS:0] rem_sum;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign id_ok      = 32'(i_in.slot_id) < SLOT_COUNT;
    assign ida        = t_addr'(i_in.slot_id);
    assign per_sat    = (32'(i_in.period_ms) > 32'(DELAY_MAX)) ? DELAY_MAX
                                                                : t_delay'(i_in.period_ms);
    assign s_ext      = t_idx'(r_s);
    assign due_sel    = r_due[r_idx[DUE_AW-1:0]];
    assign rem_sum    = {1'b0, r_rd_delta} + {1'b0, r_sd};

    assign ins_done = (r_state == S_INS_LINK) ||
                      ((r_state == S_INS_WS) && (r_eq || r_prev == NO_SLOT));

    assign res_last = !(r_adv && r_cnt != '0) || (r_idx == r_cnt - 1'b1);
    assign out_load = (r_state == S_EMIT) && out_free;

    always_comb begin
        res.event_kind    = KIND_DONE;
        res.expired_slot  = '0;
        if (r_adv && r_cnt != '0) begin
            res.event_kind   = KIND_EXPIRED;
            res.expired_slot = 4'(due_sel);
        end else begin
            res.event_kind   = r_kind;
        end
        res.head_delay_ms = 24'(r_hd);
        res.last          = res_last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.operation == OP_ADD && id_ok && !r_active[ida]) begin
                        n_state = S_INS_RD;
                    end else if (i_in.operation == OP_REMOVE && id_ok && r_active[ida]) begin
                        n_state = S_REM_RD;
                    end else if (i_in.operation == OP_ADV) begin
                        n_state = S_ADV_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_INS_RD: begin
                n_state = (r_cur == NO_SLOT) ? S_INS_WS : S_INS_CMP;
            end
            S_INS_CMP: begin
                n_state = (r_d > r_rd_delta) ? S_INS_RD : S_INS_WS;
            end
            S_INS_WS: begin
                if (ins_done) begin
                    n_state = r_adv ? S_ADV_P2 : S_FIN;
                end else begin
                    n_state = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                n_state = r_adv ? S_ADV_P2 : S_FIN;
            end
            S_REM_RD: begin
                n_state = (r_cur == NO_SLOT) ? S_FIN : S_REM_CMP;
            end
            S_REM_CMP: begin
                if (r_cur == s_ext) begin
                    n_state = (r_rd_succ == NO_SLOT) ? S_REM_LINK : S_REM_ADD;
                end else begin
                    n_state = S_REM_RD;
                end
            end
            S_REM_ADD: begin
                n_state = S_REM_LINK;
            end
            S_REM_LINK: begin
                n_state = S_FIN;
            end
            S_ADV_RD: begin
                if (r_head == NO_SLOT || r_cnt == CNT_W'(MAX_RESULTS)) begin
                    n_state = S_ADV_P2;
                end else begin
                    n_state = S_ADV_CMP;
                end
            end
            S_ADV_CMP: begin
                n_state = (t_cmp'(r_rd_delta) > t_cmp'(r_e)) ? S_ADV_P2 : S_ADV_RD;
            end
            S_ADV_P2: begin
                n_state = (r_idx == r_cnt) ? S_FIN : S_ADV_PR;
            end
            S_ADV_PR: begin
                n_state = r_prd_rep ? S_INS_RD : S_ADV_P2;
            end
            S_FIN: begin
                n_state = (r_head == NO_SLOT) ? S_EMIT : S_FIN_RD;
            end
            S_FIN_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load && res_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_adv    = r_adv;
        n_kind   = r_kind;
        n_s      = r_s;
        n_d      = r_d;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_pd     = r_pd;
        n_nx     = r_nx;
        n_sd     = r_sd;
        n_eq     = r_eq;
        n_e      = r_e;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_head   = r_head;
        n_hd     = r_hd;
        n_active = r_active;
        n_due    = r_due;
        lm_we     = 1'b0;
        lm_waddr  = r_s;
        lm_wdelta = r_d;
        lm_wsucc  = r_nx;
        lm_raddr  = r_cur[AW-1:0];
        pm_we     = 1'b0;
        pm_addr   = due_sel;
        unique case (r_state)
            S_IDLE: begin
                pm_addr = ida;
                if (accept) begin
                    n_adv  = (i_in.operation == OP_ADV);
                    n_kind = KIND_DONE;
                    n_cnt  = '0;
                    n_idx  = '0;
                    n_s    = ida;
                    n_d    = per_sat;
                    n_prev = NO_SLOT;
                    n_cur  = r_head;
                    n_eq   = 1'b0;
                    n_e    = i_in.elapsed_ms;
                    if (i_in.operation == OP_ADD && id_ok) begin
                        if (r_active[ida]) begin
                            n_kind = KIND_REJECT;
                        end else begin
                            pm_we         = 1'b1;
                            n_active[ida] = 1'b1;
                        end
                    end else if (i_in.operation == OP_REMOVE && id_ok) begin
                        n_active[ida] = 1'b0;
                    end
                end
            end
            S_INS_RD: begin
                if (r_cur == NO_SLOT) begin
                    n_nx = NO_SLOT;
                end
            end
            S_INS_CMP: begin
                lm_waddr = r_cur[AW-1:0];
                if (r_d > r_rd_delta) begin
                    n_d    = r_d - r_rd_delta;
                    n_prev = r_cur;
                    n_pd   = r_rd_delta;
                    n_cur  = r_rd_succ;
                end else if (r_d == r_rd_delta) begin
                    lm_we     = 1'b1;
                    lm_wdelta = r_rd_delta;
                    lm_wsucc  = s_ext;
                    n_d       = '0;
                    n_nx      = r_rd_succ;
                    n_eq      = 1'b1;
                end else begin
                    lm_we     = 1'b1;
                    lm_wdelta = r_rd_delta - r_d;
                    lm_wsucc  = r_rd_succ;
                    n_nx      = r_cur;
                end
            end
            S_INS_WS: begin
                lm_we = 1'b1;
                if (!r_eq && r_prev == NO_SLOT) begin
                    n_head = s_ext;
                end
                if (ins_done && r_adv) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_INS_LINK: begin
                lm_we     = 1'b1;
                lm_waddr  = r_prev[AW-1:0];
                lm_wdelta = r_pd;
                lm_wsucc  = s_ext;
                if (r_adv) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_REM_CMP: begin
                if (r_cur == s_ext) begin
                    n_nx     = r_rd_succ;
                    n_sd     = r_rd_delta;
                    lm_raddr = r_rd_succ[AW-1:0];
                end else begin
                    n_prev = r_cur;
                    n_pd   = r_rd_delta;
                    n_cur  = r_rd_succ;
                end
            end
            S_REM_ADD: begin
                lm_we     = 1'b1;
                lm_waddr  = r_nx[AW-1:0];
                lm_wdelta = rem_sum[DELAY_BITS] ? DELAY_MAX : rem_sum[DELAY_BITS-1:0];
                lm_wsucc  = r_rd_succ;
            end
            S_REM_LINK: begin
                if (r_prev == NO_SLOT) begin
                    n_head = r_nx;
                end else begin
                    lm_we     = 1'b1;
                    lm_waddr  = r_prev[AW-1:0];
                    lm_wdelta = r_pd;
                    lm_wsucc  = r_nx;
                end
            end
            S_ADV_RD: begin
                lm_raddr = r_head[AW-1:0];
            end
            S_ADV_CMP: begin
                if (t_cmp'(r_rd_delta) > t_cmp'(r_e)) begin
                    lm_we     = 1'b1;
                    lm_waddr  = r_head[AW-1:0];
                    lm_wdelta = r_rd_delta - t_delay'(r_e);
                    lm_wsucc  = r_rd_succ;
                end else begin
                    n_e                      = r_e - 16'(r_rd_delta);
                    n_due[r_cnt[DUE_AW-1:0]] = r_head[AW-1:0];
                    n_cnt                    = r_cnt + 1'b1;
                    n_head                   = r_rd_succ;
                end
            end
            S_ADV_P2: begin
                pm_addr = due_sel;
            end
            S_ADV_PR: begin
                if (r_prd_rep) begin
                    n_s    = due_sel;
                    n_d    = r_prd_per;
                    n_prev = NO_SLOT;
                    n_cur  = r_head;
                    n_eq   = 1'b0;
                end else begin
                    n_active[due_sel] = 1'b0;
                    n_idx             = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                n_idx    = '0;
                lm_raddr = r_head[AW-1:0];
                if (r_head == NO_SLOT) begin
                    n_hd = '0;
                end
            end
            S_FIN_RD: begin
                n_hd = r_rd_delta;
            end
            S_EMIT: begin
                if (out_load && !res_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_head   <= NO_SLOT;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adv  <= n_adv;
        r_kind <= n_kind;
        r_s    <= n_s;
        r_d    <= n_d;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_pd   <= n_pd;
        r_nx   <= n_nx;
        r_sd   <= n_sd;
        r_eq   <= n_eq;
        r_e    <= n_e;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_hd   <= n_hd;
        r_due  <= n_due;
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            m_delta[lm_waddr] <= lm_wdelta;
            m_succ[lm_waddr]  <= lm_wsucc;
        end
        r_rd_delta <= m_delta[lm_raddr];
        r_rd_succ  <= m_succ[lm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            m_per[pm_addr] <= per_sat;
            m_rep[pm_addr] <= i_in.periodic;
        end
        r_prd_per <= m_per[pm_addr];
        r_prd_rep <= m_rep[pm_addr];
    end

    dltq_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("Expiry count exceeds the result limit.");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NO_SLOT)
        else $error("List head index out of range.");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NO_SLOT) == (r_active == '0)))
        else $error("List head disagrees with the active slots.");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_EMIT))
        else $error("Result word issued outside the emit state.");

endmodule
